// ===== src/scmt_pkg.sv =====
package scmt_pkg;

  localparam int SCALE_W    = 14;
  localparam int SCALE_FRAC = 12;
  localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(1 << SCALE_FRAC);
  localparam logic [SCALE_W-1:0] SCALE_LO  = SCALE_W'(1 << (SCALE_FRAC - 1));
  localparam logic [SCALE_W-1:0] SCALE_HI  = SCALE_W'(3 << SCALE_FRAC);

  localparam int DIST_W = 22;
  localparam int TIME_W = 26;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  localparam int NUM_W = 67;
  localparam int DEN_W = 47;
  localparam int QUO_W = 26;
  localparam int CNT_W = $clog2(QUO_W + 1);

  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 27;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam logic [1:0] OP_OBSERVE   = 2'd0;
  localparam logic [1:0] OP_ESCAPE    = 2'd1;
  localparam logic [1:0] OP_MOVE      = 2'd2;
  localparam logic [1:0] OP_SAFE_MOVE = 2'd3;

  localparam logic [2:0] REG_MAX_SPEED  = 3'd0;
  localparam logic [2:0] REG_PWM_CAP    = 3'd1;
  localparam logic [2:0] REG_DEADZONE   = 3'd2;
  localparam logic [2:0] REG_WHEEL      = 3'd3;
  localparam logic [2:0] REG_MIN_TIME   = 3'd4;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic             ovf;
    logic [QUO_W-1:0] quo;
  } div_res_t;

endpackage

// ===== src/scmt_div.sv =====
module scmt_div import scmt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_res_t res_o
);

  logic [DEN_W-1:0] rem_q, den_q;
  logic [QUO_W-1:0] quo_q;
  logic             ovf_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;

  logic [DEN_W:0] trial, diff;
  logic           ge;

  assign trial = {rem_q, quo_q[QUO_W-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(QUO_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= DEN_W'(req_i.num[NUM_W-1:QUO_W]);
      quo_q <= req_i.num[QUO_W-1:0];
      den_q <= req_i.den;
      ovf_q <= DEN_W'(req_i.num[NUM_W-1:QUO_W]) >= req_i.den;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_q <= {quo_q[QUO_W-2:0], ge};
    end
  end

  assign res_o.done = done_q;
  assign res_o.ovf  = ovf_q;
  assign res_o.quo  = quo_q;

endmodule

// ===== src/self_calibrating_move_time.sv =====
// Accepted calibration samples and move time queries use the shared 32x27
// multiplier and the 26-step restoring divider in turn. The input is ready only
// in the idle state, so a new item is taken only once the last one has reached
// the output stage. A finished result waits in the output register while the next item is taken.
// Reset (async, active low) restores the state, the configuration registers to
// their defaults, the scale to 1.0 and the sample count to zero.
module self_calibrating_move_time import scmt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // speed, distance_a, distance_b, time_cap, pad
  input  logic [1:0]  s_axis_tuser,   // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // move_time, scale_now, sample_count
  output logic        m_axis_tuser,   // accepted
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_CAL_GATE = 4'd1;
  localparam logic [3:0] ST_CAL_DIV  = 4'd2;
  localparam logic [3:0] ST_CAL_WAIT = 4'd3;
  localparam logic [3:0] ST_PWM_MUL  = 4'd4;
  localparam logic [3:0] ST_PWM_DIV  = 4'd5;
  localparam logic [3:0] ST_PWM_WAIT = 4'd6;
  localparam logic [3:0] ST_M2       = 4'd7;
  localparam logic [3:0] ST_M3       = 4'd8;
  localparam logic [3:0] ST_M4       = 4'd9;
  localparam logic [3:0] ST_M5       = 4'd10;
  localparam logic [3:0] ST_MT_DIV   = 4'd11;
  localparam logic [3:0] ST_MT_WAIT  = 4'd12;
  localparam logic [3:0] ST_PUSH     = 4'd13;

  logic [3:0]         state_q, state_d;
  logic [7:0]         msp_q, capr_q, dz_q;
  logic [19:0]        wheel_q;
  logic [23:0]        minmt_q;
  logic [SCALE_W-1:0] scale_q, scale_d;
  logic [7:0]         samp_q, samp_d;

  logic [1:0]         op_q;
  logic [8:0]         spd_q;
  logic [DIST_W-1:0]  dist_a_q, dist_b_q;
  logic [TIME_W-1:0]  tcap_q;

  logic [PROD_W-1:0]  prod_q;
  logic [26:0]        den_cal_q;
  logic [7:0]         pwm_q;
  logic [54:0]        num_q;
  logic [18:0]        gain_q;
  logic [TIME_W-1:0]  res_time_q;
  logic               res_ok_q;

  logic               out_valid_q;
  logic [TIME_W-1:0]  out_time_q;
  logic [SCALE_W-1:0] out_scale_q;
  logic [7:0]         out_samp_q;
  logic               out_ok_q;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  div_req_t           div_req;
  div_res_t           div_res;

  logic [7:0]  msp_eff, cap_eff;
  logic [19:0] wheel_eff;
  logic [8:0]  mag;
  logic [7:0]  s_lim, span;
  logic        safe;
  logic [4:0]  gn;
  logic [26:0] kgd;
  logic [26:0] a27, b27;
  logic        esc, gate_ok;
  logic [26:0] coef, den_cal;
  logic [8:0]  psum;
  logic [7:0]  pwm_fix;
  logic [SCALE_W-1:0] scale_clamp;
  logic [TIME_W-1:0]  tq, tmin, tfin;
  logic        in_acc, push;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = state_q == ST_IDLE;
  assign cfg_ready_o   = 1'b1;
  assign push          = state_q == ST_PUSH && (!out_valid_q || m_axis_tready);

  assign msp_eff   = (msp_q == '0) ? 8'd1 : msp_q;
  assign cap_eff   = (capr_q == '0) ? 8'd1 : capr_q;
  assign wheel_eff = (wheel_q == '0) ? 20'd1 : wheel_q;

  // speed magnitude, then limit to [1, max speed]
  assign mag = spd_q[8] ? 9'(10'd512 - {1'b0, spd_q}) : spd_q;
  always_comb begin
    if (mag == '0) s_lim = 8'd1;
    else if (mag > {1'b0, msp_eff}) s_lim = msp_eff;
    else s_lim = mag[7:0];
  end
  assign span = (cap_eff > dz_q) ? cap_eff - dz_q : 8'd0;

  assign safe = op_q == OP_SAFE_MOVE;
  always_comb begin
    if (!safe) begin
      gn  = 5'd1;
      kgd = 27'd1000000;
    end else if (samp_q >= 8'd3) begin
      gn  = 5'd23;
      kgd = 27'd20000000;
    end else begin
      gn  = 5'd9;
      kgd = 27'd5000000;
    end
  end

  // calibration gates and update terms
  assign a27 = 27'(dist_a_q);
  assign b27 = 27'(dist_b_q);
  assign esc = op_q == OP_ESCAPE;
  always_comb begin
    if (esc) begin
      gate_ok = a27 >= 27'd10000 && b27 >= 27'd2000 &&
                ((b27 << 2) + b27) >= (a27 << 1) &&
                b27 <= ((a27 << 1) + a27);
      coef    = (a27 << 2) + b27;
      den_cal = (a27 << 2) + a27;
    end else begin
      gate_ok = a27 >= 27'd20000 &&
                ((b27 << 3) + (b27 << 1)) >= ((a27 << 1) + a27) &&
                (b27 << 1) <= ((a27 << 3) - a27);
      coef    = (a27 << 4) + a27 + (b27 << 1) + b27;
      den_cal = (a27 << 4) + (a27 << 2);
    end
  end

  assign psum = {1'b0, dz_q} + {1'b0, div_res.quo[7:0]};
  always_comb begin
    if (psum > {1'b0, cap_eff}) pwm_fix = cap_eff;
    else if (psum == '0) pwm_fix = 8'd1;
    else pwm_fix = psum[7:0];
  end

  always_comb begin
    if (div_res.quo < QUO_W'(SCALE_LO)) scale_clamp = SCALE_LO;
    else if (div_res.quo > QUO_W'(SCALE_HI)) scale_clamp = SCALE_HI;
    else scale_clamp = div_res.quo[SCALE_W-1:0];
  end

  assign tq   = div_res.ovf ? TIME_MAX : div_res.quo[TIME_W-1:0];
  assign tmin = (tq < TIME_W'(minmt_q)) ? TIME_W'(minmt_q) : tq;
  always_comb begin
    if (dist_a_q == '0) tfin = '0;
    else if (tcap_q != '0 && tmin > tcap_q) tfin = tcap_q;
    else tfin = tmin;
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_CAL_GATE: begin
        mul_a = MUL_A_W'(scale_q);
        mul_b = coef;
      end
      ST_PWM_MUL: begin
        mul_a = MUL_A_W'(s_lim);
        mul_b = MUL_B_W'(span);
      end
      ST_PWM_WAIT: begin
        mul_a = MUL_A_W'(dist_a_q);
        mul_b = MUL_B_W'(cap_eff);
      end
      ST_M2: begin
        mul_a = prod_q[MUL_A_W-1:0];
        mul_b = kgd;
      end
      ST_M3: begin
        mul_a = MUL_A_W'(scale_q);
        mul_b = MUL_B_W'(gn);
      end
      ST_M4: begin
        mul_a = MUL_A_W'(wheel_eff);
        mul_b = MUL_B_W'(pwm_q);
      end
      ST_M5: begin
        mul_a = prod_q[MUL_A_W-1:0];
        mul_b = MUL_B_W'(gain_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = '0;
    case (state_q)
      ST_CAL_DIV: begin
        div_req.start = 1'b1;
        div_req.num   = NUM_W'(prod_q[40:0]) + NUM_W'(den_cal_q[26:1]);
        div_req.den   = DEN_W'(den_cal_q);
      end
      ST_PWM_DIV: begin
        div_req.start = 1'b1;
        div_req.num   = NUM_W'(prod_q[16:0]);
        div_req.den   = DEN_W'(msp_eff);
      end
      ST_MT_DIV: begin
        div_req.start = 1'b1;
        div_req.num   = {num_q, {SCALE_FRAC{1'b0}}};
        div_req.den   = prod_q[DEN_W-1:0];
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  scmt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .res_o  (div_res)
  );

  always_comb begin
    state_d = state_q;
    scale_d = scale_q;
    samp_d  = samp_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser == OP_OBSERVE || s_axis_tuser == OP_ESCAPE) state_d = ST_CAL_GATE;
          else state_d = ST_PWM_MUL;
        end
      end
      ST_CAL_GATE: state_d = gate_ok ? ST_CAL_DIV : ST_PUSH;
      ST_CAL_DIV:  state_d = ST_CAL_WAIT;
      ST_CAL_WAIT: begin
        if (div_res.done) begin
          scale_d = scale_clamp;
          if (samp_q != 8'hFF) samp_d = samp_q + 8'd1;
          state_d = ST_PUSH;
        end
      end
      ST_PWM_MUL:  state_d = ST_PWM_DIV;
      ST_PWM_DIV:  state_d = ST_PWM_WAIT;
      ST_PWM_WAIT: if (div_res.done) state_d = ST_M2;
      ST_M2:       state_d = ST_M3;
      ST_M3:       state_d = ST_M4;
      ST_M4:       state_d = ST_M5;
      ST_M5:       state_d = ST_MT_DIV;
      ST_MT_DIV:   state_d = ST_MT_WAIT;
      ST_MT_WAIT:  if (div_res.done) state_d = ST_PUSH;
      ST_PUSH:     if (push) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      msp_q       <= 8'd80;
      capr_q      <= 8'd255;
      dz_q        <= 8'd170;
      wheel_q     <= 20'd165000;
      minmt_q     <= 24'd70000;
      scale_q     <= SCALE_ONE;
      samp_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      scale_q <= scale_d;
      samp_q  <= samp_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_MAX_SPEED: msp_q   <= cfg_data_i[7:0];
          REG_PWM_CAP:   capr_q  <= cfg_data_i[7:0];
          REG_DEADZONE:  dz_q    <= cfg_data_i[7:0];
          REG_WHEEL:     wheel_q <= cfg_data_i[19:0];
          REG_MIN_TIME:  minmt_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (push) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
    if (in_acc) begin
      op_q     <= s_axis_tuser;
      spd_q    <= s_axis_tdata[8:0];
      dist_a_q <= s_axis_tdata[30:9];
      dist_b_q <= s_axis_tdata[52:31];
      tcap_q   <= s_axis_tdata[78:53];
    end
    case (state_q)
      ST_CAL_GATE: begin
        den_cal_q  <= den_cal;
        res_time_q <= '0;
        res_ok_q   <= gate_ok;
      end
      ST_PWM_WAIT: pwm_q  <= pwm_fix;
      ST_M3:       num_q  <= prod_q[54:0];
      ST_M4:       gain_q <= prod_q[18:0];
      ST_MT_WAIT: begin
        res_time_q <= tfin;
        res_ok_q   <= 1'b0;
      end
      default: begin
      end
    endcase
    if (push) begin
      out_time_q  <= res_time_q;
      out_scale_q <= scale_q;
      out_samp_q  <= samp_q;
      out_ok_q    <= res_ok_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_samp_q, out_scale_q, out_time_q};
  assign m_axis_tuser  = out_ok_q;

endmodule
